// ===== rtl/cll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg
// Shared constants, status codes and the CORDIC rotation table function.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam logic [63:0] HALF_TURN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] INV_TWO_PI   = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0] RADIUS_RESET = 64'd6370987308;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_POLAR  = 2'd1,
    ST_ORIGIN = 2'd2
  } status_t;

  // restoring long division, used for table build only
  function automatic logic [63:0] div_long(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in turns at 2^64
  function automatic logic [63:0] rot_entry(input int i);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    int           span;
    sum = '0;
    if (i == 0) begin
      return 64'h2000_0000_0000_0000;
    end
    for (int k = 0; k < 63; k++) begin
      span = i * (2 * k + 1);
      if (span <= 62) begin
        term = div_long(64'd1 << (62 - span), 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_TWO_PI};
    return prod[125:62];
  endfunction

endpackage

// ===== rtl/cll_pos_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pos_if
// Position channel: valid/ready with x, y, z payload.
// ----------------------------------------------------------------------------
interface cll_pos_if #(parameter int POS_WIDTH = 40);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== rtl/cll_geo_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_geo_if
// Result channel: valid/ready with longitude, latitude, altitude and status.
// ----------------------------------------------------------------------------
interface cll_geo_if #(parameter int ANGLE_WIDTH = 32, parameter int POS_WIDTH = 40);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] longitude;
  logic signed [ANGLE_WIDTH-1:0] latitude;
  logic signed [POS_WIDTH-1:0]   altitude_mm;
  logic [1:0]                    status;
  modport source (output valid, longitude, latitude, altitude_mm, status, input ready);
  modport sink   (input valid, longitude, latitude, altitude_mm, status, output ready);
endinterface

// ===== rtl/cll_root_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_root_cell
// One bit step of two square roots, digit pair BIT of the radicand.
// ----------------------------------------------------------------------------
module cll_root_cell #(
  parameter int P   = 40,
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [1:0][2*P-1:0]   n_i,
  input  logic [1:0][P+1:0]     rem_i,
  input  logic [1:0][P:0]       r_i,
  input  logic [SW-1:0]         sb_i,
  output logic                  valid_r,
  output logic [1:0][2*P-1:0]   n_r,
  output logic [1:0][P+1:0]     rem_r,
  output logic [1:0][P:0]       r_r,
  output logic [SW-1:0]         sb_r
);

  logic [1:0][P+1:0] rem_s;
  logic [1:0][P+1:0] trial;
  logic [1:0][P+1:0] rem_nxt;
  logic [1:0][P:0]   r_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_s[l] = {rem_i[l][P-1:0], n_i[l][2*BIT +: 2]};
      trial[l] = {r_i[l][P-1:0], 2'b01};
      if (rem_s[l] >= trial[l]) begin
        rem_nxt[l] = rem_s[l] - trial[l];
        r_nxt[l]   = {r_i[l][P-1:0], 1'b1};
      end else begin
        rem_nxt[l] = rem_s[l];
        r_nxt[l]   = {r_i[l][P-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_i;
      rem_r <= rem_nxt;
      r_r   <= r_nxt;
      sb_r  <= sb_i;
    end
  end

endmodule

// ===== rtl/cll_norm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_norm_cell
// One step of the binary normalising shift for two operand pairs.
// ----------------------------------------------------------------------------
module cll_norm_cell #(
  parameter int SH = 1,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  logic [1:0][63:0] x_i,
  input  logic [1:0][63:0] y_i,
  input  logic [SW-1:0]    sb_i,
  output logic             valid_r,
  output logic [1:0][63:0] x_r,
  output logic [1:0][63:0] y_r,
  output logic [SW-1:0]    sb_r
);

  localparam int LIM = 61 - SH;

  logic [1:0][63:0] x_nxt;
  logic [1:0][63:0] y_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if ((x_i[l] >> LIM) == 64'd0 && (y_i[l] >> LIM) == 64'd0) begin
        x_nxt[l] = x_i[l] << SH;
        y_nxt[l] = y_i[l] << SH;
      end else begin
        x_nxt[l] = x_i[l];
        y_nxt[l] = y_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      sb_r <= sb_i;
    end
  end

endmodule

// ===== rtl/cll_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_cordic_cell
// One vectoring CORDIC micro-rotation for two lanes.
// ----------------------------------------------------------------------------
module cll_cordic_cell
  import cll_pkg::*;
#(
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  logic [1:0][63:0] x_i,
  input  logic [1:0][63:0] y_i,
  input  logic [1:0][63:0] acc_i,
  input  logic [SW-1:0]    sb_i,
  output logic             valid_r,
  output logic [1:0][63:0] x_r,
  output logic [1:0][63:0] y_r,
  output logic [1:0][63:0] acc_r,
  output logic [SW-1:0]    sb_r
);

  localparam logic [63:0] ENTRY = rot_entry(IDX);

  logic [1:0][63:0] x_nxt;
  logic [1:0][63:0] y_nxt;
  logic [1:0][63:0] acc_nxt;
  logic [1:0][63:0] dx;
  logic [1:0][63:0] dy;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = 64'($signed(y_i[l]) >>> IDX);
      dy[l] = 64'($signed(x_i[l]) >>> IDX);
      if (!y_i[l][63]) begin
        x_nxt[l]   = x_i[l] + dx[l];
        y_nxt[l]   = y_i[l] - dy[l];
        acc_nxt[l] = acc_i[l] + ENTRY;
      end else begin
        x_nxt[l]   = x_i[l] - dx[l];
        y_nxt[l]   = y_i[l] + dy[l];
        acc_nxt[l] = acc_i[l] - ENTRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
      sb_r  <= sb_i;
    end
  end

endmodule

// ===== rtl/cartesian_to_lon_lat_alt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_lon_lat_alt_core
// Earth-fixed x, y, z to geocentric longitude, latitude and altitude.
//
//   port     dir  handshake     beat
//   in_ch    in   valid/ready   pos_x, pos_y, pos_z
//   out_ch   out  valid/ready   longitude, latitude, altitude_mm, status
//   cfg_*    in   write enable  earth_radius_mm
//
// One beat per cycle while out_ch is not stalled; the pipeline runs through the
// bit-serial root chain, the normalise chain and the CORDIC chain.
// Synchronous active-low reset clears all valid flags; radius to default.
// A stalled output holds the whole chain; in_ch.ready follows that enable.
// ----------------------------------------------------------------------------
module cartesian_to_lon_lat_alt_core
  import cll_pkg::*;
#(
  parameter int POS_WIDTH     = 40,
  parameter int ANGLE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [POS_WIDTH-1:0] cfg_wdata,
  cll_pos_if.sink              in_ch,
  cll_geo_if.source            out_ch
);

  localparam int P    = POS_WIDTH;
  localparam int H    = (P + 1) / 2;
  localparam int HI   = P - H;
  localparam int W2   = 2 * P;
  localparam int SW_R = 3 * P + 3;
  localparam int SW_C = P + 9;
  localparam int NS   = 6;
  localparam int CS   = CORDIC_STAGES;
  localparam logic [63:0] HALF_OUT = 64'd1 << (63 - ANGLE_WIDTH);
  localparam logic [P:0]  LIM_POS  = {2'b00, {(P-1){1'b1}}};
  localparam logic [P-1:0] LIM_NEG = {1'b1, {(P-1){1'b0}}};

  logic         en;
  logic [P-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET[P-1:0];
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // input magnitudes
  logic [2:0][P-1:0] mag_nxt;
  logic [2:0]        neg_nxt;
  logic [2:0][P-1:0] mag0_r, mag1_r, mag2_r, mag3_r;
  logic [2:0]        neg0_r, neg1_r, neg2_r, neg3_r;
  logic              v0_r, v1_r, v2_r, v3_r;

  always_comb begin
    neg_nxt[0] = in_ch.pos_x[P-1];
    neg_nxt[1] = in_ch.pos_y[P-1];
    neg_nxt[2] = in_ch.pos_z[P-1];
    mag_nxt[0] = neg_nxt[0] ? P'(~in_ch.pos_x + 1'b1) : P'(in_ch.pos_x);
    mag_nxt[1] = neg_nxt[1] ? P'(~in_ch.pos_y + 1'b1) : P'(in_ch.pos_y);
    mag_nxt[2] = neg_nxt[2] ? P'(~in_ch.pos_z + 1'b1) : P'(in_ch.pos_z);
  end

  // partial products, squares, sums
  logic [2:0][2*HI-1:0] pp_hh_r;
  logic [2:0][HI+H-1:0] pp_hl_r;
  logic [2:0][2*H-1:0]  pp_ll_r;
  logic [2:0][W2-1:0]   sq_r;
  logic [W2-1:0]        nxy_r, nall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r <= mag_nxt;
      neg0_r <= neg_nxt;
      mag1_r <= mag0_r;
      neg1_r <= neg0_r;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
      for (int k = 0; k < 3; k++) begin
        pp_hh_r[k] <= mag0_r[k][P-1:H] * mag0_r[k][P-1:H];
        pp_hl_r[k] <= mag0_r[k][P-1:H] * mag0_r[k][H-1:0];
        pp_ll_r[k] <= mag0_r[k][H-1:0] * mag0_r[k][H-1:0];
        sq_r[k]    <= (W2'(pp_hh_r[k]) << (2 * H)) + (W2'(pp_hl_r[k]) << (H + 1))
                      + W2'(pp_ll_r[k]);
      end
      nxy_r  <= sq_r[0] + sq_r[1];
      nall_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // root chain
  logic                  rt_v   [P+1];
  logic [1:0][W2-1:0]    rt_n   [P+1];
  logic [1:0][P+1:0]     rt_rem [P+1];
  logic [1:0][P:0]       rt_r   [P+1];
  logic [SW_R-1:0]       rt_sb  [P+1];

  assign rt_v[0]   = v3_r;
  assign rt_n[0]   = {nall_r, nxy_r};
  assign rt_rem[0] = '0;
  assign rt_r[0]   = '0;
  assign rt_sb[0]  = {mag3_r, neg3_r};

  for (genvar j = 0; j < P; j++) begin : g_root
    cll_root_cell #(.P(P), .BIT(P - 1 - j), .SW(SW_R)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (rt_v[j]),
      .n_i     (rt_n[j]),
      .rem_i   (rt_rem[j]),
      .r_i     (rt_r[j]),
      .sb_i    (rt_sb[j]),
      .valid_r (rt_v[j+1]),
      .n_r     (rt_n[j+1]),
      .rem_r   (rt_rem[j+1]),
      .r_r     (rt_r[j+1]),
      .sb_r    (rt_sb[j+1])
    );
  end

  // round roots, then altitude and lane set-up
  logic            v4_r, v5_r;
  logic [P:0]      rho_r, rng_r;
  logic [SW_R-1:0] sb4_r;
  logic [2:0][P-1:0] mag4;
  logic [2:0]        neg4;
  logic [P:0]      d_hi;
  logic [P-1:0]    d_lo;
  logic [P-1:0]    alt_nxt;
  status_t         st_nxt;
  logic [3:0]      zf_nxt;
  logic [1:0][63:0] nx_nxt, ny_nxt;
  logic [1:0][63:0] nx5_r, ny5_r;
  logic [SW_C-1:0] sb5_r;

  assign {mag4, neg4} = sb4_r;

  always_comb begin
    d_hi    = rng_r - {1'b0, radius_r};
    d_lo    = radius_r - P'(rng_r);
    if (rng_r >= {1'b0, radius_r}) begin
      alt_nxt = (d_hi > LIM_POS) ? LIM_POS[P-1:0] : d_hi[P-1:0];
    end else begin
      alt_nxt = (d_lo > LIM_NEG) ? LIM_NEG : P'(~d_lo + 1'b1);
    end
    if (mag4[0] == '0 && mag4[1] == '0) begin
      st_nxt = (mag4[2] == '0) ? ST_ORIGIN : ST_POLAR;
    end else begin
      st_nxt = ST_NORMAL;
    end
    zf_nxt    = {rho_r == '0, mag4[2] == '0, mag4[0] == '0, mag4[1] == '0};
    nx_nxt[0] = 64'(mag4[0]);
    ny_nxt[0] = 64'(mag4[1]);
    nx_nxt[1] = 64'(rho_r);
    ny_nxt[1] = 64'(mag4[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= rt_v[P];
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rho_r <= rt_r[P][0] + (P+1)'(rt_rem[P][0] > {1'b0, rt_r[P][0]});
      rng_r <= rt_r[P][1] + (P+1)'(rt_rem[P][1] > {1'b0, rt_r[P][1]});
      sb4_r <= rt_sb[P];
      nx5_r <= nx_nxt;
      ny5_r <= ny_nxt;
      sb5_r <= {alt_nxt, neg4, st_nxt, zf_nxt};
    end
  end

  // normalise chain
  logic             nm_v  [NS+1];
  logic [1:0][63:0] nm_x  [NS+1];
  logic [1:0][63:0] nm_y  [NS+1];
  logic [SW_C-1:0]  nm_sb [NS+1];

  assign nm_v[0]  = v5_r;
  assign nm_x[0]  = nx5_r;
  assign nm_y[0]  = ny5_r;
  assign nm_sb[0] = sb5_r;

  for (genvar j = 0; j < NS; j++) begin : g_norm
    cll_norm_cell #(.SH(1 << (NS - 1 - j)), .SW(SW_C)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (nm_v[j]),
      .x_i     (nm_x[j]),
      .y_i     (nm_y[j]),
      .sb_i    (nm_sb[j]),
      .valid_r (nm_v[j+1]),
      .x_r     (nm_x[j+1]),
      .y_r     (nm_y[j+1]),
      .sb_r    (nm_sb[j+1])
    );
  end

  // CORDIC chain
  logic             cd_v   [CS+1];
  logic [1:0][63:0] cd_x   [CS+1];
  logic [1:0][63:0] cd_y   [CS+1];
  logic [1:0][63:0] cd_acc [CS+1];
  logic [SW_C-1:0]  cd_sb  [CS+1];

  assign cd_v[0]   = nm_v[NS];
  assign cd_x[0]   = nm_x[NS];
  assign cd_y[0]   = nm_y[NS];
  assign cd_acc[0] = '0;
  assign cd_sb[0]  = nm_sb[NS];

  for (genvar j = 0; j < CS; j++) begin : g_cordic
    cll_cordic_cell #(.IDX(j), .SW(SW_C)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (cd_v[j]),
      .x_i     (cd_x[j]),
      .y_i     (cd_y[j]),
      .acc_i   (cd_acc[j]),
      .sb_i    (cd_sb[j]),
      .valid_r (cd_v[j+1]),
      .x_r     (cd_x[j+1]),
      .y_r     (cd_y[j+1]),
      .acc_r   (cd_acc[j+1]),
      .sb_r    (cd_sb[j+1])
    );
  end

  // clamp and fold into quadrant
  logic [P-1:0]     f_alt;
  logic [2:0]       f_neg;
  logic [1:0]       f_st;
  logic [3:0]       f_zf;
  logic [1:0][63:0] qa;
  logic [63:0]      lon_nxt, lat_nxt;
  logic             v6_r, vout_r;
  logic [63:0]      lon6_r, lat6_r;
  logic [P-1:0]     alt6_r;
  logic [1:0]       st6_r;
  logic [ANGLE_WIDTH-1:0] lon_out_r, lat_out_r;
  logic [P-1:0]     alt_out_r;
  logic [1:0]       st_out_r;

  assign {f_alt, f_neg, f_st, f_zf} = cd_sb[CS];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (f_zf[2*l]) begin
        qa[l] = '0;
      end else if (f_zf[2*l+1]) begin
        qa[l] = QUARTER_TURN;
      end else if (cd_acc[CS][l] >= HALF_TURN) begin
        qa[l] = '0;
      end else if (cd_acc[CS][l] > QUARTER_TURN) begin
        qa[l] = QUARTER_TURN;
      end else begin
        qa[l] = cd_acc[CS][l];
      end
    end
    case ({f_neg[0], f_neg[1]})
      2'b00:   lon_nxt = qa[0];
      2'b10:   lon_nxt = HALF_TURN - qa[0];
      2'b11:   lon_nxt = qa[0] - HALF_TURN;
      2'b01:   lon_nxt = ~qa[0] + 64'd1;
      default: lon_nxt = qa[0];
    endcase
    lat_nxt = f_neg[2] ? (~qa[1] + 64'd1) : qa[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r   <= 1'b0;
      vout_r <= 1'b0;
    end else if (en) begin
      v6_r   <= cd_v[CS];
      vout_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon6_r    <= lon_nxt;
      lat6_r    <= lat_nxt;
      alt6_r    <= f_alt;
      st6_r     <= f_st;
      lon_out_r <= ANGLE_WIDTH'((lon6_r + HALF_OUT) >> (64 - ANGLE_WIDTH));
      lat_out_r <= ANGLE_WIDTH'((lat6_r + HALF_OUT) >> (64 - ANGLE_WIDTH));
      alt_out_r <= alt6_r;
      st_out_r  <= st6_r;
    end
  end

  assign out_ch.valid       = vout_r;
  assign out_ch.longitude   = lon_out_r;
  assign out_ch.latitude    = lat_out_r;
  assign out_ch.altitude_mm = alt_out_r;
  assign out_ch.status      = st_out_r;

endmodule

// ===== sim/tb_cartesian_to_lon_lat_alt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_lon_lat_alt_core
// Checks the Cartesian to longitude, latitude and altitude core against a
// bit-exact fixed-point predictor: directed corner positions, then random
// positions under several radius settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_cartesian_to_lon_lat_alt_core;
  import cll_pkg::*;

  localparam int PW         = 40;
  localparam int AW         = 32;
  localparam int STAGES     = 32;
  localparam int PIPE_LAT   = PW + STAGES + 14;
  localparam int CYCLE_CAP  = 400000;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [63:0] LIM_POS = (64'd1 << (PW - 1)) - 64'd1;
  localparam logic [63:0] POS_SPAN = 64'd1 << PW;

  typedef struct packed {
    logic [AW-1:0] longitude;
    logic [AW-1:0] latitude;
    logic [PW-1:0] altitude_mm;
    status_t       status;
  } geo_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PW-1:0] cfg_wdata;

  cll_pos_if #(.POS_WIDTH(PW)) pos_ch ();
  cll_geo_if #(.ANGLE_WIDTH(AW), .POS_WIDTH(PW)) geo_ch ();

  cartesian_to_lon_lat_alt_core #(
    .POS_WIDTH(PW), .ANGLE_WIDTH(AW), .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(pos_ch), .out_ch(geo_ch)
  );

  geo_t        pending_geo[$];
  logic [63:0] atan_lut[STAGES];
  logic [63:0] radius_mm;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          fail_count;
  int          cycle_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] atan_turns(input int i);
    logic [63:0]  sum;
    logic [127:0] prod;
    int           span;
    sum = '0;
    if (i == 0) return 64'd1 << 61;
    for (int k = 0; k < 63; k++) begin
      span = i * (2 * k + 1);
      if (span <= 62) begin
        if (k % 2 == 1) sum = sum - (64'd1 << (62 - span)) / 64'(2 * k + 1);
        else sum = sum + (64'd1 << (62 - span)) / 64'(2 * k + 1);
      end
    end
    prod = {64'd0, sum} * {64'd0, INV_TWO_PI};
    return prod[125:62];
  endfunction

  function automatic logic [63:0] root_nearest(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] trial;
    r   = '0;
    rem = '0;
    for (int p = 47; p >= 0; p--) begin
      rem   = (rem << 2) | 64'(n[2*p +: 2]);
      trial = (r << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r   = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    if (rem > r) r = r + 64'd1;
    return r;
  endfunction

  function automatic logic [63:0] first_quadrant_angle(input logic [63:0] ax,
                                                       input logic [63:0] ay);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [63:0] acc;
    acc = '0;
    if (ay == 0) return 64'd0;
    if (ax == 0) return QUARTER_TURN;
    while (ax < (64'd1 << 60) && ay < (64'd1 << 60)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = longint'(ax);
    y = longint'(ay);
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; acc = acc + atan_lut[i];
      end else begin
        x = x - dx; y = y + dy; acc = acc - atan_lut[i];
      end
    end
    if (acc >= HALF_TURN) return 64'd0;
    if (acc > QUARTER_TURN) return QUARTER_TURN;
    return acc;
  endfunction

  function automatic logic [AW-1:0] turns_to_angle(input logic [63:0] a);
    logic [63:0] t;
    t = (a + (64'd1 << (63 - AW))) >> (64 - AW);
    return t[AW-1:0];
  endfunction

  function automatic logic [63:0] abs_pos(input logic signed [PW-1:0] v);
    return v[PW-1] ? POS_SPAN - {24'd0, v} : {24'd0, v};
  endfunction

  function automatic geo_t predict_geo(input logic signed [PW-1:0] px,
                                       input logic signed [PW-1:0] py,
                                       input logic signed [PW-1:0] pz);
    logic [63:0]  ax, ay, az, rho, range_mm, lon, lat, a, b, d, alt;
    logic [127:0] acc2;
    geo_t         g;
    ax = abs_pos(px);
    ay = abs_pos(py);
    az = abs_pos(pz);
    acc2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    rho = root_nearest(acc2);
    acc2 = acc2 + {64'd0, az} * {64'd0, az};
    range_mm = root_nearest(acc2);
    lon = '0;
    lat = '0;
    if (ax == 0 && ay == 0) begin
      if (az == 0) begin
        g.status = ST_ORIGIN;
      end else begin
        g.status = ST_POLAR;
        lat = pz[PW-1] ? 64'd0 - QUARTER_TURN : QUARTER_TURN;
      end
    end else begin
      g.status = ST_NORMAL;
      a = first_quadrant_angle(ax, ay);
      b = first_quadrant_angle(rho, az);
      case ({px[PW-1], py[PW-1]})
        2'b00: lon = a;
        2'b10: lon = HALF_TURN - a;
        2'b11: lon = 64'd0 - (HALF_TURN - a);
        default: lon = 64'd0 - a;
      endcase
      lat = pz[PW-1] ? 64'd0 - b : b;
    end
    if (range_mm >= radius_mm) begin
      d = range_mm - radius_mm;
      alt = (d > LIM_POS) ? LIM_POS : d;
    end else begin
      d = radius_mm - range_mm;
      if (d > LIM_POS + 64'd1) d = LIM_POS + 64'd1;
      alt = POS_SPAN - d;
    end
    g.longitude   = turns_to_angle(lon);
    g.latitude    = turns_to_angle(lat);
    g.altitude_mm = alt[PW-1:0];
    return g;
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_pos(input logic signed [PW-1:0] px,
                          input logic signed [PW-1:0] py,
                          input logic signed [PW-1:0] pz);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      pos_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    pos_ch.valid <= 1'b1;
    pos_ch.pos_x <= px;
    pos_ch.pos_y <= py;
    pos_ch.pos_z <= pz;
    do @(posedge clk); while (!pos_ch.ready);
    pending_geo.push_back(predict_geo(px, py, pz));
    @(negedge clk);
  endtask

  task automatic write_radius(input logic [PW-1:0] value);
    pos_ch.valid <= 1'b0;
    while (pending_geo.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    radius_mm = {24'd0, value};
  endtask

  function automatic logic signed [PW-1:0] random_coord();
    logic signed [PW-1:0] v;
    v = PW'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0, 1: return v;
      2:    return v >>> $urandom_range(0, PW - 1);
      3:    return '0;
      4: begin
        case ($urandom_range(0, 3))
          0: return POS_MAX;
          1: return POS_MIN;
          2: return PW'(1);
          default: return -PW'(1);
        endcase
      end
      default: return v >>> 6;
    endcase
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_corners();
    send_pos(POS_MAX, 0, 0);
    send_pos(POS_MIN, 0, 0);
    send_pos(0, POS_MAX, 0);
    send_pos(0, POS_MIN, 0);
    send_pos(0, 0, POS_MAX);
    send_pos(0, 0, POS_MIN);
    send_pos(0, 0, 0);
    send_pos(POS_MAX, POS_MAX, POS_MAX);
    send_pos(POS_MIN, POS_MIN, POS_MIN);
    send_pos(POS_MAX, POS_MIN, POS_MIN);
    send_pos(-PW'(1), 0, 0);
    send_pos(-PW'(1), -PW'(1), -PW'(1));
    send_pos(PW'(1), PW'(1), PW'(1));
    send_pos(-PW'(64'd4000000000), PW'(64'd3000000000), PW'(64'd5000000000));
    send_pos(-PW'(64'd4000000000), -PW'(64'd3000000000), -PW'(64'd5000000000));
    send_pos(PW'(64'd4000000000), -PW'(64'd3000000000), PW'(1));
    send_pos(0, PW'(7), -PW'(3));
    send_pos(PW'(64'd6370987308), 0, 0);
    send_pos(0, 0, -PW'(1));
  endtask

  task automatic test_random(input int n_items);
    for (int n = 0; n < n_items; n++) begin
      send_pos(random_coord(), random_coord(), random_coord());
    end
  endtask

  // ------------------------------------------------------------------ checker
  always @(negedge clk) begin
    if (rst_n) geo_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    geo_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n && geo_ch.valid && geo_ch.ready) begin
      if (pending_geo.size() == 0) begin
        $error("result beat with no position pending");
        fail_count = fail_count + 1;
      end else begin
        want = pending_geo.pop_front();
        if (geo_ch.longitude !== want.longitude) begin
          $error("longitude: expected %h, got %h", want.longitude, geo_ch.longitude);
          fail_count = fail_count + 1;
        end
        if (geo_ch.latitude !== want.latitude) begin
          $error("latitude: expected %h, got %h", want.latitude, geo_ch.latitude);
          fail_count = fail_count + 1;
        end
        if (geo_ch.altitude_mm !== want.altitude_mm) begin
          $error("altitude_mm: expected %h, got %h", want.altitude_mm, geo_ch.altitude_mm);
          fail_count = fail_count + 1;
        end
        if (geo_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, geo_ch.status);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------- main
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    pos_ch.valid = 1'b0;
    pos_ch.pos_x = '0;
    pos_ch.pos_y = '0;
    pos_ch.pos_z = '0;
    geo_ch.ready = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;
    radius_mm    = RADIUS_RESET;
    tx_idle_pct  = 36;
    rx_idle_pct  = 50;
    for (int i = 0; i < STAGES; i++) atan_lut[i] = atan_turns(i);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corners();
    test_random(450);
    write_radius({PW{1'b1}});
    test_corners();
    test_random(150);
    tx_idle_pct = 50;
    rx_idle_pct = 36;
    write_radius('0);
    test_corners();
    test_random(450);
    write_radius(PW'({$urandom, $urandom}));
    test_random(150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_radius(PW'(RADIUS_RESET));
    test_random(450);
    pos_ch.valid <= 1'b0;

    while (pending_geo.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
